// File: src/bgpb_pkg.sv
// bgpb_pkg: shared constants, types and divider step for the bitmap glyph pixel blender
// used by every module of the block; depends on nothing
package bgpb_pkg;

   // glyph geometry defaults
   localparam int GLYPH_WIDTH_DEF  = 12;
   localparam int GLYPH_HEIGHT_DEF = 16;
   localparam int GLYPH_COUNT_DEF  = 256;

   // font memory
   localparam int FONT_ADDR_W  = 13;
   localparam int FONT_DEPTH   = 1 << FONT_ADDR_W;
   localparam int FULL_ADDR_W  = 16;

   // field widths
   localparam int COORD_W  = 8;
   localparam int CODE_W   = 8;
   localparam int BYTE_W   = 8;
   localparam int SCALE_W  = 4;
   localparam int PIXEL_W  = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // divider pipeline shape
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = COORD_W / DIV_STEPS_PER_STAGE;

   // register indexes
   typedef enum logic [1:0] {
      CSR_TEXT_COLOR = 2'd0,
      CSR_BACK_COLOR = 2'd1,
      CSR_SCALE      = 2'd2
   } csr_index_type;

   // item operations
   typedef enum logic {
      OP_FONT_WRITE = 1'b0,
      OP_RENDER     = 1'b1
   } op_type;

   // payload that travels along the divider
   typedef struct packed {
      op_type                  operation;
      logic [FONT_ADDR_W-1:0]  font_address;
      logic [BYTE_W-1:0]       font_byte;
      logic [CODE_W-1:0]       char_code;
      logic [PIXEL_W-1:0]      dest_pixel;
   } bgpb_item_type;

   // restoring divider state: partial remainder and dividend/quotient bits
   typedef struct packed {
      logic [SCALE_W-1:0] rem;
      logic [COORD_W-1:0] bits;
   } bgpb_div_type;

   // payload from the memory stage to the blend stage
   typedef struct packed {
      logic               render;
      logic [2:0]         bit_sel;
      logic [PIXEL_W-1:0] dest_pixel;
   } bgpb_pix_type;

   // one restoring division step: shift in the next dividend bit, subtract if it fits
   function automatic bgpb_div_type div_step(bgpb_div_type cur, logic [SCALE_W-1:0] divisor);
      logic [SCALE_W:0] trial;
      logic             qbit;
      bgpb_div_type     nxt;
      trial = {cur.rem, cur.bits[COORD_W-1]};
      qbit  = (trial >= {1'b0, divisor});
      if (qbit) begin
         nxt.rem = SCALE_W'(trial - {1'b0, divisor});
      end else begin
         nxt.rem = trial[SCALE_W-1:0];
      end
      nxt.bits = {cur.bits[COORD_W-2:0], qbit};
      return nxt;
   endfunction

endpackage

// File: src/bgpb_divider.sv
// bgpb_divider: pipelined restoring divider of cell column and row by the scale
// carries the item payload alongside; depends on bgpb_pkg
module bgpb_divider
   import bgpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bgpb_item_type       in_item,
   input  logic [COORD_W-1:0]  in_col,
   input  logic [COORD_W-1:0]  in_row,
   input  logic [SCALE_W-1:0]  divisor,
   output logic                out_valid,
   input  logic                out_ready,
   output bgpb_item_type       out_item,
   output logic [COORD_W-1:0]  out_fx,
   output logic [COORD_W-1:0]  out_fy
);

   logic          valid_ff [DIV_STAGES];
   bgpb_item_type item_ff  [DIV_STAGES];
   bgpb_div_type  col_ff   [DIV_STAGES];
   bgpb_div_type  row_ff   [DIV_STAGES];
   bgpb_item_type item_in  [DIV_STAGES];
   bgpb_div_type  col_in   [DIV_STAGES];
   bgpb_div_type  row_in   [DIV_STAGES];
   logic [DIV_STAGES:0] stage_en;

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      stage_en[DIV_STAGES] = out_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // each stage retires a fixed number of quotient bits
   always_comb begin
      bgpb_div_type c;
      bgpb_div_type r;
      // first stage starts from the incoming coordinates
      c.rem  = '0;
      c.bits = in_col;
      r.rem  = '0;
      r.bits = in_row;
      for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
         c = div_step(c, divisor);
         r = div_step(r, divisor);
      end
      col_in[0]  = c;
      row_in[0]  = r;
      item_in[0] = in_item;
      // later stages continue from the previous stage registers
      for (int k = 1; k < DIV_STAGES; k++) begin
         c = col_ff[k-1];
         r = row_ff[k-1];
         for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
            c = div_step(c, divisor);
            r = div_step(r, divisor);
         end
         col_in[k]  = c;
         row_in[k]  = r;
         item_in[k] = item_ff[k-1];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < DIV_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (stage_en[k]) begin
            col_ff[k]  <= col_in[k];
            row_ff[k]  <= row_in[k];
            item_ff[k] <= item_in[k];
         end
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_item  = item_ff[DIV_STAGES-1];
   assign out_fx    = col_ff[DIV_STAGES-1].bits;
   assign out_fy    = row_ff[DIV_STAGES-1].bits;

endmodule

// File: src/bgpb_font_mem.sv
// bgpb_font_mem: glyph address generation and the single-port font memory stage
// one write or one registered read per item; depends on bgpb_pkg
module bgpb_font_mem
   import bgpb_pkg::*;
#(
   parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
   parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
   parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bgpb_item_type       in_item,
   input  logic [COORD_W-1:0]  in_fx,
   input  logic [COORD_W-1:0]  in_fy,
   output logic                out_valid,
   input  logic                out_ready,
   output bgpb_pix_type        out_pix,
   output logic [BYTE_W-1:0]   out_rdata
);

   localparam int ROW_BYTES    = GLYPH_WIDTH / 8 + 1;
   localparam int GLYPH_STRIDE = GLYPH_HEIGHT * ROW_BYTES;

   logic [BYTE_W-1:0]      font_mem [FONT_DEPTH];
   logic [BYTE_W-1:0]      rdata_ff;
   logic                   valid_ff;
   bgpb_pix_type           pix_ff;
   bgpb_pix_type           pix_in;
   logic                   stage_en;
   logic                   load;
   logic                   in_glyph;
   logic [FULL_ADDR_W-1:0] full_addr;
   logic [FONT_ADDR_W-1:0] rd_addr;

   assign stage_en = !valid_ff || out_ready;
   assign load     = stage_en && in_valid;

   // glyph bounds and byte address, wrapped to the memory size
   assign in_glyph = ({1'b0, in_fx} < 9'(GLYPH_WIDTH)) &&
                     ({1'b0, in_fy} < 9'(GLYPH_HEIGHT)) &&
                     ({1'b0, in_item.char_code} < 9'(GLYPH_COUNT));
   assign full_addr = FULL_ADDR_W'(in_item.char_code) * FULL_ADDR_W'(GLYPH_STRIDE) +
                      FULL_ADDR_W'(in_fy) * FULL_ADDR_W'(ROW_BYTES) +
                      FULL_ADDR_W'(in_fx >> 3);
   assign rd_addr   = full_addr[FONT_ADDR_W-1:0];

   always_comb begin
      pix_in.render     = (in_item.operation == OP_RENDER) && in_glyph;
      pix_in.bit_sel    = in_fx[2:0];
      pix_in.dest_pixel = in_item.dest_pixel;
   end

   // font memory: write items store, render items read
   always_ff @(posedge clock) begin
      if (load) begin
         if (in_item.operation == OP_FONT_WRITE) begin
            font_mem[in_item.font_address] <= in_item.font_byte;
         end else begin
            rdata_ff <= font_mem[rd_addr];
         end
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= pix_in;
      end
   end

   assign in_ready  = stage_en;
   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
   assign out_rdata = rdata_ff;

endmodule

// File: src/bgpb_blend.sv
// bgpb_blend: glyph bit select, color choice, alpha blend and result register
// depends on bgpb_pkg
module bgpb_blend
   import bgpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bgpb_pix_type        in_pix,
   input  logic [BYTE_W-1:0]   in_rdata,
   input  logic [PIXEL_W-1:0]  text_color,
   input  logic [PIXEL_W-1:0]  back_color,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_write_enable,
   output logic [PIXEL_W-1:0]  out_new_pixel
);

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam int                SUM_W        = 2 * BYTE_W;

   logic               valid_ff;
   logic               we_ff;
   logic [PIXEL_W-1:0] pixel_ff;
   logic               we_in;
   logic [PIXEL_W-1:0] pixel_in;
   logic               stage_en;
   logic               glyph_bit;
   logic [PIXEL_W-1:0] color;
   logic [BYTE_W-1:0]  alpha;
   logic [PIXEL_W-1:0] blended;

   // (a*c + (255-a)*d) >> 8 for one channel
   function automatic logic [BYTE_W-1:0] blend_channel(logic [BYTE_W-1:0] a,
                                                       logic [BYTE_W-1:0] c,
                                                       logic [BYTE_W-1:0] d);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(a) * SUM_W'(c) + SUM_W'(ALPHA_OPAQUE - a) * SUM_W'(d);
      return sum[SUM_W-1:BYTE_W];
   endfunction

   assign stage_en = !valid_ff || out_ready;

   // msb-first bit pick: bit 7 - column mod 8
   assign glyph_bit = in_rdata[~in_pix.bit_sel];
   assign color     = glyph_bit ? text_color : back_color;
   assign alpha     = color[31:24];

   always_comb begin
      blended[7:0]   = blend_channel(alpha, color[7:0],   in_pix.dest_pixel[7:0]);
      blended[15:8]  = blend_channel(alpha, color[15:8],  in_pix.dest_pixel[15:8]);
      blended[23:16] = blend_channel(alpha, color[23:16], in_pix.dest_pixel[23:16]);
      blended[31:24] = ALPHA_OPAQUE;
   end

   // skip on transparent, copy on opaque, blend otherwise
   always_comb begin
      we_in = in_pix.render && (alpha != '0);
      priority if (!we_in) begin
         pixel_in = '0;
      end else if (alpha == ALPHA_OPAQUE) begin
         pixel_in = color;
      end else begin
         pixel_in = blended;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         we_ff    <= we_in;
         pixel_ff <= pixel_in;
      end
   end

   assign in_ready         = stage_en;
   assign out_valid        = valid_ff;
   assign out_write_enable = we_ff;
   assign out_new_pixel    = pixel_ff;

endmodule

// File: src/bitmap_glyph_pixel_blender.sv
// Bitmap glyph pixel blender. Takes one item per clock, sustained while rsp_tready is high: a font
// write item stores a byte in the 8192 x 8 font memory, a render item divides its cell column and
// row by the scale, reads the glyph byte and returns the pixel to write over dest_pixel (text or
// background color, skipped at alpha 0, copied at alpha 255, blended per channel otherwise with
// alpha forced to 255). Every item gives exactly one result item; font writes and skipped pixels
// return write_enable 0 and new_pixel 0. Registers on the path: four divider stages (two quotient
// bits per stage), the register of the single-port font memory, and the result register. Items
// flow in order through the one memory port, so a render item always sees every earlier font
// write. The font memory has no reset; reading a byte that was never written gives an undefined
// pixel. Registers (APB, 4-byte spacing): text_color, back_color, scale (0 acts as 1); write them
// only with no items in flight.
//
// top level: csr block and stream ports; instantiates bgpb_divider, bgpb_font_mem, bgpb_blend
// depends on bgpb_pkg
module bitmap_glyph_pixel_blender
   import bgpb_pkg::*;
#(
   parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
   parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
   parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request item stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // font_address[12:0], font_byte[20:13], char_code[28:21], cell_column[36:29],
   // cell_row[44:37], dest_pixel[76:45], zero pad[79:77]
   input  logic [79:0]            req_tdata,
   // operation[0]
   input  logic                   req_tuser,
   // result item stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // new_pixel[31:0]
   output logic [PIXEL_W-1:0]     rsp_tdata,
   // write_enable[0]
   output logic                   rsp_tuser,
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [PIXEL_W-1:0] text_color_ff;
   logic [PIXEL_W-1:0] back_color_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [SCALE_W-1:0] divisor;
   logic               csr_write;
   csr_index_type      csr_index;

   bgpb_item_type      req_item;
   logic               div_valid;
   logic               div_ready;
   bgpb_item_type      div_item;
   logic [COORD_W-1:0] div_fx;
   logic [COORD_W-1:0] div_fy;
   logic               mem_valid;
   logic               mem_ready;
   bgpb_pix_type       mem_pix;
   logic [BYTE_W-1:0]  mem_rdata;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= 32'hFFFF_FFFF;
         back_color_ff <= 32'hFF00_0000;
         scale_ff      <= SCALE_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TEXT_COLOR: text_color_ff <= csr_pwdata;
            CSR_BACK_COLOR: back_color_ff <= csr_pwdata;
            CSR_SCALE:      scale_ff      <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_TEXT_COLOR: csr_prdata = text_color_ff;
         CSR_BACK_COLOR: csr_prdata = back_color_ff;
         CSR_SCALE:      csr_prdata = CSR_DATA_W'(scale_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // a zero scale acts as one
   assign divisor = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;

   // unpack request item
   always_comb begin
      req_item.operation    = op_type'(req_tuser);
      req_item.font_address = req_tdata[12:0];
      req_item.font_byte    = req_tdata[20:13];
      req_item.char_code    = req_tdata[28:21];
      req_item.dest_pixel   = req_tdata[76:45];
   end

   bgpb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .in_col    (req_tdata[36:29]),
      .in_row    (req_tdata[44:37]),
      .divisor   (divisor),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item),
      .out_fx    (div_fx),
      .out_fy    (div_fy)
   );

   bgpb_font_mem #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_font_mem (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_item   (div_item),
      .in_fx     (div_fx),
      .in_fy     (div_fy),
      .out_valid (mem_valid),
      .out_ready (mem_ready),
      .out_pix   (mem_pix),
      .out_rdata (mem_rdata)
   );

   bgpb_blend u_blend (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (mem_valid),
      .in_ready         (mem_ready),
      .in_pix           (mem_pix),
      .in_rdata         (mem_rdata),
      .text_color       (text_color_ff),
      .back_color       (back_color_ff),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_write_enable (rsp_tuser),
      .out_new_pixel    (rsp_tdata)
   );

   // skipped pixels carry a zero word
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("skipped pixel with nonzero data");

   // every written pixel is opaque, copied or blended
   a_write_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:24] == 8'hFF)
      else $error("written pixel not opaque");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // the divisor taken from the scale register is never zero
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      divisor != '0)
      else $error("zero divisor");

endmodule

// File: test/bitmap_glyph_pixel_blender_tb.sv
// bitmap_glyph_pixel_blender_tb: self-checking bench for the glyph pixel blender, stream in/out
// with an apb csr port; a scoreboard class keeps its own font memory and colors to predict pixels
// depends on bgpb_pkg and the bitmap_glyph_pixel_blender rtl
`timescale 1ns / 100ps

module bitmap_glyph_pixel_blender_tb
   import bgpb_pkg::*;
();

   // one request item as the bench sees it
   typedef struct packed {
      op_type                  operation;
      logic [FONT_ADDR_W-1:0]  font_address;
      logic [BYTE_W-1:0]       font_byte;
      logic [CODE_W-1:0]       char_code;
      logic [COORD_W-1:0]      cell_column;
      logic [COORD_W-1:0]      cell_row;
      logic [PIXEL_W-1:0]      dest_pixel;
   } glyph_req_type;

   // font copy, colors and scale; predicts the pixel of each accepted item
   class glyph_pixel_scoreboard;
      typedef struct packed {
         logic               write_enable;
         logic [PIXEL_W-1:0] new_pixel;
      } pixel_result_type;

      pixel_result_type   expected_pixels[$];
      logic [BYTE_W-1:0]  font_bytes[FONT_DEPTH];
      bit                 font_written[FONT_DEPTH];
      logic [PIXEL_W-1:0] text_color = 32'hFFFF_FFFF;
      logic [PIXEL_W-1:0] back_color = 32'hFF00_0000;
      logic [SCALE_W-1:0] scale      = 4'd1;
      int                 errors     = 0;

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         unique case (idx)
            CSR_TEXT_COLOR: text_color = value;
            CSR_BACK_COLOR: back_color = value;
            CSR_SCALE:      scale = value[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      // font byte and bit behind a cell position; 0 when outside the glyph
      function bit glyph_spot(logic [CODE_W-1:0] code, logic [COORD_W-1:0] col,
                              logic [COORD_W-1:0] row, output logic [FONT_ADDR_W-1:0] addr,
                              output logic [2:0] bit_pos);
         int s;
         int fx;
         int fy;
         int row_bytes;
         s = (scale == 0) ? 1 : int'(scale);
         fx = int'(col) / s;
         fy = int'(row) / s;
         row_bytes = GLYPH_WIDTH_DEF / 8 + 1;
         addr = '0;
         bit_pos = '0;
         if (fx >= GLYPH_WIDTH_DEF || fy >= GLYPH_HEIGHT_DEF || int'(code) >= GLYPH_COUNT_DEF)
            return 1'b0;
         addr = FONT_ADDR_W'(int'(code) * GLYPH_HEIGHT_DEF * row_bytes + fy * row_bytes + fx / 8);
         bit_pos = 3'(7 - fx % 8);
         return 1'b1;
      endfunction

      // true when a render reads no font byte that was not loaded
      function bit can_render(logic [CODE_W-1:0] code, logic [COORD_W-1:0] col,
                              logic [COORD_W-1:0] row);
         logic [FONT_ADDR_W-1:0] addr;
         logic [2:0]             bit_pos;
         if (!glyph_spot(code, col, row, addr, bit_pos))
            return 1'b1;
         return font_written[addr];
      endfunction

      // per channel mix, alpha forced opaque
      function logic [PIXEL_W-1:0] blend(logic [PIXEL_W-1:0] src, logic [PIXEL_W-1:0] dst);
         logic [PIXEL_W-1:0] mixed;
         int                 a;
         int                 v;
         a = int'(src[31:24]);
         mixed = 32'hFF00_0000;
         for (int lane = 0; lane < 3; lane++) begin
            v = (a * int'(src[8*lane +: 8]) + (255 - a) * int'(dst[8*lane +: 8])) >> 8;
            mixed[8*lane +: 8] = v[7:0];
         end
         return mixed;
      endfunction

      function void note_item(glyph_req_type r);
         pixel_result_type       res;
         logic [FONT_ADDR_W-1:0] addr;
         logic [2:0]             bit_pos;
         logic [PIXEL_W-1:0]     clr;
         res.write_enable = 1'b0;
         res.new_pixel = '0;
         if (r.operation == OP_FONT_WRITE) begin
            font_bytes[r.font_address] = r.font_byte;
            font_written[r.font_address] = 1'b1;
         end else if (glyph_spot(r.char_code, r.cell_column, r.cell_row, addr, bit_pos)) begin
            clr = font_bytes[addr][bit_pos] ? text_color : back_color;
            // transparent color leaves the pixel alone
            if (clr[31:24] != 8'h00) begin
               res.write_enable = 1'b1;
               res.new_pixel = (clr[31:24] == 8'hFF) ? clr : blend(clr, r.dest_pixel);
            end
         end
         expected_pixels.push_back(res);
      endfunction

      function void check_pixel(logic write_enable, logic [PIXEL_W-1:0] new_pixel);
         pixel_result_type exp_res;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result item write_enable %0b new_pixel %h",
                     $time, write_enable, new_pixel);
            errors++;
            return;
         end
         exp_res = expected_pixels.pop_front();
         if (write_enable !== exp_res.write_enable) begin
            $display("%0t: write_enable expected %0b got %0b",
                     $time, exp_res.write_enable, write_enable);
            errors++;
         end
         if (new_pixel !== exp_res.new_pixel) begin
            $display("%0t: new_pixel expected %h got %h", $time, exp_res.new_pixel, new_pixel);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // font_address, font_byte, char_code, cell_column, cell_row, dest_pixel, zero pad
   logic [79:0]           req_tdata = '0;
   // operation
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // new_pixel
   logic [PIXEL_W-1:0]    rsp_tdata;
   // write_enable
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   glyph_pixel_scoreboard sb = new();
   int                    send_idle_pct = 10;
   int                    recv_idle_pct = 60;
   int                    items_sent = 0;
   logic [CODE_W-1:0]     loaded_glyphs[$];
   bit                    glyph_loaded[GLYPH_COUNT_DEF];

   bitmap_glyph_pixel_blender dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pixel(rsp_tuser, rsp_tdata);
   end

   // run limit
   initial begin
      #10_000_000;
      $display("** bitmap_glyph_pixel_blender: FAILED **");
      $finish;
   end

   function automatic glyph_req_type make_write(logic [FONT_ADDR_W-1:0] addr,
                                                logic [BYTE_W-1:0] b);
      glyph_req_type r;
      r.operation = OP_FONT_WRITE;
      r.font_address = addr;
      r.font_byte = b;
      r.char_code = CODE_W'($urandom_range(255));
      r.cell_column = COORD_W'($urandom_range(179));
      r.cell_row = COORD_W'($urandom_range(239));
      r.dest_pixel = $urandom;
      return r;
   endfunction

   function automatic glyph_req_type make_render(logic [CODE_W-1:0] code,
                                                 logic [COORD_W-1:0] col,
                                                 logic [COORD_W-1:0] row,
                                                 logic [PIXEL_W-1:0] dest);
      glyph_req_type r;
      r.operation = OP_RENDER;
      r.font_address = FONT_ADDR_W'($urandom_range(FONT_DEPTH - 1));
      r.font_byte = BYTE_W'($urandom_range(255));
      r.char_code = code;
      r.cell_column = col;
      r.cell_row = row;
      r.dest_pixel = dest;
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(glyph_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.operation;
      req_tdata <= {3'b000, r.dest_pixel, r.cell_row, r.cell_column, r.char_code, r.font_byte,
                    r.font_address};
      do @(posedge clock); while (!req_tready);
      sb.note_item(r);
      items_sent++;
      @(negedge clock);
   endtask

   // stop sending and let every expected item come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // two-phase apb write
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // whole glyph as one burst of font writes
   task automatic load_glyph(logic [CODE_W-1:0] code);
      for (int i = 0; i < GLYPH_HEIGHT_DEF * (GLYPH_WIDTH_DEF / 8 + 1); i++)
         send_item(make_write(FONT_ADDR_W'(int'(code) * 32 + i),
                              BYTE_W'($urandom_range(255))));
      if (!glyph_loaded[code]) begin
         glyph_loaded[code] = 1'b1;
         loaded_glyphs.push_back(code);
      end
   endtask

   initial begin
      logic [PIXEL_W-1:0] text_set;
      logic [PIXEL_W-1:0] back_set;
      logic [SCALE_W-1:0] scale_set;
      logic [CODE_W-1:0]  code;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      int                 start;
      int                 pick;
      int                 s;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: corner bytes of glyphs 0 and 255 at reset colors and scale
      send_item(make_write(13'd0, 8'hA5));
      send_item(make_write(13'd1, 8'h5A));
      send_item(make_write(13'd30, 8'h81));
      send_item(make_write(13'd31, 8'hF0));
      send_item(make_write(13'd8160, 8'hFF));
      send_item(make_write(13'd8161, 8'h0F));
      send_item(make_write(13'd8190, 8'h00));
      send_item(make_write(13'd8191, 8'h0F));
      send_item(make_render(8'd0, 8'd0, 8'd0, 32'h0000_0000));
      send_item(make_render(8'd0, 8'd1, 8'd0, 32'hFFFF_FFFF));
      send_item(make_render(8'd0, 8'd7, 8'd0, 32'h1234_5678));
      send_item(make_render(8'd0, 8'd8, 8'd0, 32'hFFFF_FFFF));
      send_item(make_render(8'd0, 8'd11, 8'd15, 32'h0000_0000));
      send_item(make_render(8'd255, 8'd0, 8'd0, 32'hFFFF_FFFF));
      send_item(make_render(8'd255, 8'd11, 8'd0, 32'h0000_0000));
      send_item(make_render(8'd255, 8'd11, 8'd15, 32'hFFFF_FFFF));
      send_item(make_render(8'd255, 8'd0, 8'd15, 32'h0000_0000));
      // outside the glyph in column, row and both
      send_item(make_render(8'd0, 8'd12, 8'd0, 32'hFFFF_FFFF));
      send_item(make_render(8'd0, 8'd0, 8'd16, 32'hFFFF_FFFF));
      send_item(make_render(8'd255, 8'd179, 8'd239, 32'h0000_0000));

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         unique case (phase)
            0: begin
               text_set = {8'h80, 24'($urandom)};
               back_set = {8'h00, 24'($urandom)};
               scale_set = 4'd1;
            end
            1: begin
               text_set = {8'h00, 24'($urandom)};
               back_set = {8'hFF, 24'($urandom)};
               scale_set = 4'd15;
            end
            2: begin
               text_set = $urandom;
               back_set = $urandom;
               scale_set = 4'd0;
            end
            3: begin
               text_set = 32'h0000_0000;
               back_set = 32'hFFFF_FFFF;
               scale_set = 4'd2;
            end
            4: begin
               text_set = {8'($urandom_range(254, 1)), 24'($urandom)};
               back_set = {8'($urandom_range(254, 1)), 24'($urandom)};
               scale_set = 4'($urandom_range(15, 1));
            end
            default: begin
               text_set = {8'h01, 24'($urandom)};
               back_set = {8'hFE, 24'($urandom)};
               scale_set = 4'd3;
            end
         endcase
         csr_write(CSR_TEXT_COLOR, text_set);
         csr_write(CSR_BACK_COLOR, back_set);
         csr_write(CSR_SCALE, CSR_DATA_W'(scale_set));

         // idle pattern: sender light then receiver light, then none
         if (phase < 2) begin
            send_idle_pct = 10;
            recv_idle_pct = 60;
         end else if (phase < 4) begin
            send_idle_pct = 60;
            recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         if (phase == 0) begin
            load_glyph(8'd0);
            load_glyph(8'd255);
         end

         s = (scale_set == 0) ? 1 : int'(scale_set);
         start = items_sent;
         while (items_sent - start < 250) begin
            pick = $urandom_range(999);
            if (pick < 10) begin
               load_glyph(CODE_W'($urandom_range(255)));
            end else if (pick < 15) begin
               drain();
            end else if (pick < 140) begin
               send_item(make_write(FONT_ADDR_W'($urandom_range(FONT_DEPTH - 1)),
                                    BYTE_W'($urandom_range(255))));
            end else begin
               if ($urandom_range(99) < 85)
                  code = loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)];
               else
                  code = CODE_W'($urandom_range(255));
               // mostly inside the scaled cell, sometimes anywhere
               if ($urandom_range(99) < 80) begin
                  col = COORD_W'($urandom_range((s * GLYPH_WIDTH_DEF - 1 > 179) ? 179 :
                                                s * GLYPH_WIDTH_DEF - 1));
                  row = COORD_W'($urandom_range((s * GLYPH_HEIGHT_DEF - 1 > 239) ? 239 :
                                                s * GLYPH_HEIGHT_DEF - 1));
               end else begin
                  col = COORD_W'($urandom_range(179));
                  row = COORD_W'($urandom_range(239));
               end
               if (!sb.can_render(code, col, row))
                  code = loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)];
               send_item(make_render(code, col, row, $urandom));
            end
         end
      end

      drain();
      if (sb.errors == 0)
         $display("** bitmap_glyph_pixel_blender: PASSED **");
      else
         $display("** bitmap_glyph_pixel_blender: FAILED **");
      $finish;
   end

endmodule
